>>> sv/sslr_pkg.sv
// package: shared types, defaults and helpers of the segmented sliding rms unit
`default_nettype none
package sslr_pkg;

  localparam int unsigned DefSamples  = 256;
  localparam int unsigned DefSegments = 8;

  localparam int unsigned SampleW = 16;
  localparam int unsigned SquareW = 31;
  localparam int unsigned RmsW    = 16;
  localparam int unsigned SegOutW = 3;

  typedef struct packed {
    logic                      channel;
    logic signed [SampleW-1:0] sample;
  } in_t;

  typedef struct packed {
    logic               out_channel;
    logic [SegOutW-1:0] segment;
    logic [RmsW-1:0]    rms;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD0,
    ST_FIRST,
    ST_RD,
    ST_SQ,
    ST_UPD,
    ST_ROOT,
    ST_OUT
  } state_e;

  function automatic logic [SquareW-1:0] square_of(input logic signed [SampleW-1:0] v);
    logic [SampleW-1:0]   mag;
    logic [2*SampleW-1:0] prod;
    mag  = v[SampleW-1] ? SampleW'(-v) : SampleW'(v);
    prod = {{SampleW{1'b0}}, mag} * {{SampleW{1'b0}}, mag};
    return prod[SquareW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> sv/segmented_sliding_rms_unit.sv
// top level: two-channel segmented sliding rms with ring and sum memories
// one request yields one result per segment, in segment order; a new request is taken only
// after the result of its last segment has been taken.
// per segment: ring read, square, sum read-modify-write, bit-serial root, handoff.
// reset runs a clearing pass over both memories before the first request is taken.
`default_nettype none
module segmented_sliding_rms_unit #(
  parameter int unsigned SAMPLES  = sslr_pkg::DefSamples,
  parameter int unsigned SEGMENTS = sslr_pkg::DefSegments
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire sslr_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output sslr_pkg::out_t       out_data_o
);

  localparam int unsigned RW     = $clog2(SAMPLES);
  localparam int unsigned SW     = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned RemW   = SW + 1;
  localparam int unsigned ClrW   = ((RW > SW) ? RW : SW) + 1;
  localparam int unsigned SumW   = sslr_pkg::SquareW + RW;
  localparam int unsigned SegQ   = SAMPLES / SEGMENTS;
  localparam int unsigned SegR   = SAMPLES % SEGMENTS;
  localparam int unsigned SegLen = (SegQ == 0) ? 1 : SegQ;

  sslr_pkg::state_e state_q, state_d;

  logic [ClrW-1:0]                    clr_q, clr_d;
  logic [RW-1:0]                      wp_q [2];
  logic [RW-1:0]                      wp_d [2];
  logic                               ch_q, ch_d;
  logic signed [sslr_pkg::SampleW-1:0] val_q, val_d;
  logic [sslr_pkg::SquareW-1:0]       sqnew_q, sqnew_d;
  logic [sslr_pkg::SquareW-1:0]       prev_q, prev_d;
  logic [sslr_pkg::SquareW-1:0]       next_q, next_d;
  logic [RW-1:0]                      st_q, st_d;
  logic [RemW-1:0]                    rem_q, rem_d;
  logic [SW-1:0]                      seg_q, seg_d;
  sslr_pkg::out_t                     out_q, out_d;

  logic                               ring_we, ring_re;
  logic [RW:0]                        ring_waddr, ring_raddr;
  logic [sslr_pkg::SampleW-1:0]       ring_wdata, ring_rdata;
  logic                               sum_we, sum_re;
  logic [SW:0]                        sum_waddr;
  logic [SumW-1:0]                    sum_wdata, sum_rdata, sum_new;
  logic                               sq_start, sq_done;
  logic [sslr_pkg::RmsW-1:0]          sq_root;

  logic [RW-1:0]                      base;
  logic [RW:0]                        idx_sum;
  logic [RW-1:0]                      rd_idx;
  logic [RemW-1:0]                    rem_add;
  logic                               carry;
  logic [RW:0]                        st_next;
  logic                               seg_last;

  assign base     = wp_q[ch_q];
  assign idx_sum  = {1'b0, base} + {1'b0, st_q};
  assign rd_idx   = (idx_sum >= (RW+1)'(SAMPLES)) ? RW'(idx_sum - (RW+1)'(SAMPLES))
                                                  : idx_sum[RW-1:0];
  assign rem_add  = rem_q + RemW'(SegR);
  assign carry    = rem_add >= RemW'(SEGMENTS);
  assign st_next  = {1'b0, st_q} + (RW+1)'(SegQ) + (RW+1)'(carry);
  assign seg_last = seg_q == SW'(SEGMENTS - 1);
  assign sum_new  = sum_rdata - SumW'(prev_q) + SumW'(next_q);

  assign ring_raddr = {ch_q, rd_idx};

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    wp_d       = wp_q;
    ch_d       = ch_q;
    val_d      = val_q;
    sqnew_d    = sqnew_q;
    prev_d     = prev_q;
    next_d     = next_q;
    st_d       = st_q;
    rem_d      = rem_q;
    seg_d      = seg_q;
    out_d      = out_q;
    ring_we    = 1'b0;
    ring_waddr = '0;
    ring_wdata = '0;
    ring_re    = 1'b0;
    sum_we     = 1'b0;
    sum_waddr  = '0;
    sum_wdata  = '0;
    sum_re     = 1'b0;
    sq_start   = 1'b0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      sslr_pkg::ST_CLEAR: begin
        ring_we    = (clr_q >> (RW + 1)) == '0;
        ring_waddr = clr_q[RW:0];
        sum_we     = (clr_q >> (SW + 1)) == '0;
        sum_waddr  = clr_q[SW:0];
        clr_d      = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = sslr_pkg::ST_IDLE;
        end
      end
      sslr_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ch_d    = in_data_i.channel;
          val_d   = in_data_i.sample;
          sqnew_d = sslr_pkg::square_of(in_data_i.sample);
          st_d    = '0;
          rem_d   = '0;
          seg_d   = '0;
          state_d = sslr_pkg::ST_RD0;
        end
      end
      sslr_pkg::ST_RD0: begin
        ring_re = 1'b1;
        st_d    = st_next[RW-1:0];
        rem_d   = carry ? rem_add - RemW'(SEGMENTS) : rem_add;
        state_d = sslr_pkg::ST_FIRST;
      end
      sslr_pkg::ST_FIRST: begin
        prev_d  = sslr_pkg::square_of(ring_rdata);
        state_d = sslr_pkg::ST_RD;
      end
      sslr_pkg::ST_RD: begin
        sum_re = 1'b1;
        if (!seg_last) begin
          ring_re = 1'b1;
          st_d    = st_next[RW-1:0];
          rem_d   = carry ? rem_add - RemW'(SEGMENTS) : rem_add;
        end
        state_d = sslr_pkg::ST_SQ;
      end
      sslr_pkg::ST_SQ: begin
        next_d  = seg_last ? sqnew_q : sslr_pkg::square_of(ring_rdata);
        state_d = sslr_pkg::ST_UPD;
      end
      sslr_pkg::ST_UPD: begin
        sum_we    = 1'b1;
        sum_waddr = {ch_q, seg_q};
        sum_wdata = sum_new;
        prev_d    = next_q;
        sq_start  = 1'b1;
        state_d   = sslr_pkg::ST_ROOT;
      end
      sslr_pkg::ST_ROOT: begin
        if (sq_done) begin
          out_d.out_channel = ch_q;
          out_d.segment     = sslr_pkg::SegOutW'(seg_q);
          out_d.rms         = sq_root;
          out_d.last        = seg_last;
          state_d           = sslr_pkg::ST_OUT;
        end
      end
      sslr_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (seg_last) begin
            ring_we    = 1'b1;
            ring_waddr = {ch_q, base};
            ring_wdata = val_q;
            wp_d[ch_q] = (base == RW'(SAMPLES - 1)) ? '0 : base + 1'b1;
            state_d    = sslr_pkg::ST_IDLE;
          end else begin
            seg_d   = seg_q + 1'b1;
            state_d = sslr_pkg::ST_RD;
          end
        end
      end
      default: begin
        state_d = sslr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sslr_pkg::ST_CLEAR;
      clr_q   <= '0;
      wp_q[0] <= '0;
      wp_q[1] <= '0;
      seg_q   <= '0;
      ch_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      wp_q    <= wp_d;
      seg_q   <= seg_d;
      ch_q    <= ch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    sqnew_q <= sqnew_d;
    prev_q  <= prev_d;
    next_q  <= next_d;
    st_q    <= st_d;
    rem_q   <= rem_d;
    out_q   <= out_d;
  end

  assign out_data_o = out_q;

  sslr_ram #(
    .WIDTH (sslr_pkg::SampleW),
    .DEPTH (2 << RW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .re_i    (ring_re),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  sslr_ram #(
    .WIDTH (SumW),
    .DEPTH (2 << SW)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .re_i    (sum_re),
    .raddr_i ({ch_q, seg_q}),
    .rdata_o (sum_rdata)
  );

  sslr_sqrt #(
    .SUM_W   (SumW),
    .SEG_LEN (SegLen)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .sum_i   (sum_new),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted twice in a row");

  a_last_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |->
      out_data_o.segment == sslr_pkg::SegOutW'((SEGMENTS - 1) % 8))
    else $error("last flag on wrong segment");

  a_root_in_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == sslr_pkg::ST_ROOT)
    else $error("root finished outside its wait state");

endmodule
`default_nettype wire

>>> sv/sslr_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module sslr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> sv/sslr_sqrt.sv
// iterative floor square root of a sum divided by the segment length, one bit a cycle
`default_nettype none
module sslr_sqrt #(
  parameter int unsigned SUM_W   = 39,
  parameter int unsigned SEG_LEN = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [SUM_W-1:0]         sum_i,
  output logic                          done_o,
  output logic [sslr_pkg::RmsW-1:0]     root_o
);

  localparam int unsigned LenW = $clog2(SEG_LEN + 1);
  localparam int unsigned AccW = ((SUM_W > 32 + LenW) ? SUM_W : 32 + LenW) + 2;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  logic [sslr_pkg::RmsW-1:0] bit_q, bit_d;
  logic [sslr_pkg::RmsW-1:0] root_q, root_d;
  logic [AccW-1:0]           t_q, t_d;
  logic [AccW-1:0]           v_q, v_d;
  logic [AccW-1:0]           bl_q, bl_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [AccW-1:0]           cand;
  logic [AccW-1:0]           v_acc;
  logic                      fit;

  // candidate is SEG_LEN * (root + bit)^2, kept as running terms
  assign cand = t_q + v_q + bl_q;
  assign fit  = cand <= AccW'(sum_q);
  assign v_acc = fit ? (v_q + (bl_q << 1)) : v_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    root_d = root_q;
    t_d    = t_q;
    v_d    = v_q;
    bl_d   = bl_q;
    sum_d  = sum_q;
    if (start_i) begin
      busy_d = 1'b1;
      bit_d  = {1'b1, {(sslr_pkg::RmsW-1){1'b0}}};
      root_d = '0;
      t_d    = '0;
      v_d    = '0;
      bl_d   = AccW'(SEG_LEN) << (2 * (sslr_pkg::RmsW - 1));
      sum_d  = sum_i;
    end else if (busy_q) begin
      if (fit) begin
        t_d    = cand;
        root_d = root_q | bit_q;
      end
      v_d   = v_acc >> 1;
      bl_d  = bl_q >> 2;
      bit_d = bit_q >> 1;
      if (bit_q[0]) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    root_q <= root_d;
    t_q    <= t_d;
    v_q    <= v_d;
    bl_q   <= bl_d;
    sum_q  <= sum_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule
`default_nettype wire
